// ----- design/two_pool_page_frame_allocator_macros.svh -----
// Assertion macros shared by the allocator's checker.
`ifndef TWO_POOL_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define TWO_POOL_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPPFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- design/tppfa_pkg.sv -----
// Shared types and constants of the two-pool page frame allocator.
`default_nettype none

package tppfa_pkg;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned KPAGE_W   = 20;
  localparam int unsigned UPAGE_W   = 21;
  localparam int unsigned CFG_W     = 21;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [KPAGE_W-1:0] RST_KSTART = 20'd525312;
  localparam logic [KPAGE_W-1:0] RST_USTART = 20'd525824;
  localparam logic [UPAGE_W-1:0] RST_UEND   = 21'd557056;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_RANGE      = 3'd3,
    ST_FULL       = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KSTART = 2'd0,
    CFG_USTART = 2'd1,
    CFG_UEND   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_t           status;
  } result_t;

endpackage

`default_nettype wire

// ----- design/two_pool_page_frame_allocator.sv -----
// Two-pool page frame allocator: LIFO free stacks in block memories over untouched ranges.
//
//   channel  direction  tdata                tuser
//   in_      slave      [31:0] address       [1:0] operation, [2] pool
//   out_     master     [31:0] page_address  [2:0] status
//   cfg_     write      register index 0..2 on cfg_index, value on cfg_wdata
//
// An alloc served from a free stack passes through S_POP, since the stack memory read is
// registered: the popped page returns in the next cycle. Others push when accepted.
// Reset is synchronous and leaves both stacks empty; the stack memories are not cleared.
// A two-entry output queue lets the next item in while a result waits on out_tready;
// in_tready drops during a stack read or when both queue entries are full.
`default_nettype none

module two_pool_page_frame_allocator #(
  parameter int unsigned KERNEL_POOL_PAGES = 1024,
  parameter int unsigned USER_POOL_PAGES   = 32768,
  parameter int unsigned PAGE_SHIFT        = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [tppfa_pkg::ADDR_W-1:0]        in_tdata,   // address
  input  wire logic [2:0]                          in_tuser,   // operation, pool
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [tppfa_pkg::ADDR_W-1:0]             out_tdata,  // page_address
  output logic [2:0]                               out_tuser,  // status
  input  wire logic                                cfg_we,
  input  wire logic [tppfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tppfa_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int unsigned KCW = $clog2(KERNEL_POOL_PAGES + 1);
  localparam int unsigned KAW = $clog2(KERNEL_POOL_PAGES);
  localparam int unsigned UCW = $clog2(USER_POOL_PAGES + 1);
  localparam int unsigned UAW = $clog2(USER_POOL_PAGES);
  localparam int unsigned KW  = tppfa_pkg::KPAGE_W;
  localparam int unsigned UW  = tppfa_pkg::UPAGE_W;
  localparam int unsigned AW  = tppfa_pkg::ADDR_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  function automatic logic [AW-1:0] to_addr(input logic [UW-1:0] pg);
    logic [AW-1:0] wide;
    wide = AW'(pg);
    return wide << PAGE_SHIFT;
  endfunction

  // Configuration registers.
  logic [KW-1:0] kstart_r, ustart_r;
  logic [UW-1:0] uend_r;

  // Pool state.
  state_t         state_r, state_nxt;
  logic [KCW-1:0] kcnt_r, kcnt_nxt;
  logic [UCW-1:0] ucnt_r, ucnt_nxt;
  logic [KW-1:0]  ktop_r, ktop_nxt;
  logic [UW-1:0]  utop_r, utop_nxt;
  logic           pop_kern_r, pop_kern_nxt;

  // Free stack memories of 20-bit pages; a user page above 20 bits would be truncated.
  logic [KW-1:0]  kmem [KERNEL_POOL_PAGES];
  logic [KW-1:0]  umem [USER_POOL_PAGES];
  logic [KW-1:0]  krd_r;
  logic [KW-1:0]  urd_r;
  logic           kmem_we, kmem_re, umem_we, umem_re;
  logic [KAW-1:0] kmem_raddr, kmem_waddr;
  logic [UAW-1:0] umem_raddr, umem_waddr;

  // Output queue.
  logic                 out_tvalid_r, out_tvalid_nxt, sk_valid_r, sk_valid_nxt;
  tppfa_pkg::result_t   out_data_r, out_data_nxt, sk_data_r, sk_data_nxt;
  logic                 push;
  tppfa_pkg::result_t   res;

  // Decoded input.
  logic                 accept;
  tppfa_pkg::op_t       op;
  logic                 kern;
  logic [UW-1:0]        lo, hi, top_sel, top_dec;
  logic [AW-1:0]        page_w;
  logic                 misaligned, out_of_range, pool_full, cnt_zero;
  logic [KCW-1:0]       kcnt_dec;
  logic [UCW-1:0]       ucnt_dec;

  assign in_tready = (state_r == S_IDLE) && !sk_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign op        = tppfa_pkg::op_t'(in_tuser[1:0]);
  assign kern      = in_tuser[2];

  assign lo      = kern ? {1'b0, kstart_r} : {1'b0, ustart_r};
  assign hi      = kern ? {1'b0, ustart_r} : uend_r;
  assign top_sel = kern ? {1'b0, ktop_r} : utop_r;
  assign top_dec = top_sel - UW'(1);

  assign page_w       = in_tdata >> PAGE_SHIFT;
  assign misaligned   = |in_tdata[PAGE_SHIFT-1:0];
  assign out_of_range = (page_w < AW'(lo)) || (page_w >= AW'(hi));
  assign pool_full    = kern ? (kcnt_r == KCW'(KERNEL_POOL_PAGES))
                             : (ucnt_r == UCW'(USER_POOL_PAGES));
  assign cnt_zero     = kern ? (kcnt_r == '0) : (ucnt_r == '0);

  assign kcnt_dec   = kcnt_r - KCW'(1);
  assign ucnt_dec   = ucnt_r - UCW'(1);
  assign kmem_raddr = kcnt_dec[KAW-1:0];
  assign umem_raddr = ucnt_dec[UAW-1:0];
  assign kmem_waddr = kcnt_r[KAW-1:0];
  assign umem_waddr = ucnt_r[UAW-1:0];

  always_comb begin
    state_nxt    = state_r;
    kcnt_nxt     = kcnt_r;
    ucnt_nxt     = ucnt_r;
    ktop_nxt     = ktop_r;
    utop_nxt     = utop_r;
    pop_kern_nxt = pop_kern_r;
    kmem_we      = 1'b0;
    kmem_re      = 1'b0;
    umem_we      = 1'b0;
    umem_re      = 1'b0;
    push         = 1'b0;
    res.page_address = '0;
    res.status       = tppfa_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            tppfa_pkg::OP_ALLOC: begin
              if (!cnt_zero) begin
                // Pop: the page comes back from memory in the next cycle.
                if (kern) begin
                  kmem_re  = 1'b1;
                  kcnt_nxt = kcnt_dec;
                end else begin
                  umem_re  = 1'b1;
                  ucnt_nxt = ucnt_dec;
                end
                pop_kern_nxt = kern;
                state_nxt    = S_POP;
              end else if (top_sel > lo) begin
                if (kern) begin
                  ktop_nxt = top_dec[KW-1:0];
                end else begin
                  utop_nxt = top_dec;
                end
                push             = 1'b1;
                res.page_address = to_addr(top_dec);
              end else begin
                push       = 1'b1;
                res.status = tppfa_pkg::ST_EMPTY;
              end
            end
            tppfa_pkg::OP_FREE: begin
              push = 1'b1;
              if (misaligned) begin
                res.status = tppfa_pkg::ST_MISALIGNED;
              end else if (out_of_range) begin
                res.status = tppfa_pkg::ST_RANGE;
              end else if (pool_full) begin
                res.status = tppfa_pkg::ST_FULL;
              end else if (kern) begin
                kmem_we  = 1'b1;
                kcnt_nxt = kcnt_r + KCW'(1);
              end else begin
                umem_we  = 1'b1;
                ucnt_nxt = ucnt_r + UCW'(1);
              end
            end
            tppfa_pkg::OP_RESTART: begin
              push     = 1'b1;
              kcnt_nxt = '0;
              ucnt_nxt = '0;
              ktop_nxt = ustart_r;
              utop_nxt = uend_r;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        push             = 1'b1;
        res.page_address = to_addr({1'b0, pop_kern_r ? krd_r : urd_r});
        state_nxt        = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Two-entry queue: the head drives the port, the second entry catches a result
  // produced while the head is stalled.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    sk_valid_nxt   = sk_valid_r;
    sk_data_nxt    = sk_data_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = sk_valid_r;
      out_data_nxt   = sk_data_r;
      sk_valid_nxt   = 1'b0;
    end
    if (push) begin
      if (!out_tvalid_nxt) begin
        out_tvalid_nxt = 1'b1;
        out_data_nxt   = res;
      end else begin
        sk_valid_nxt = 1'b1;
        sk_data_nxt  = res;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r.page_address;
  assign out_tuser  = out_data_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kstart_r <= tppfa_pkg::RST_KSTART;
      ustart_r <= tppfa_pkg::RST_USTART;
      uend_r   <= tppfa_pkg::RST_UEND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tppfa_pkg::CFG_KSTART: kstart_r <= cfg_wdata[KW-1:0];
        tppfa_pkg::CFG_USTART: ustart_r <= cfg_wdata[KW-1:0];
        tppfa_pkg::CFG_UEND:   uend_r   <= cfg_wdata[UW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      kcnt_r       <= '0;
      ucnt_r       <= '0;
      ktop_r       <= tppfa_pkg::RST_USTART;
      utop_r       <= tppfa_pkg::RST_UEND;
      pop_kern_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      sk_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kcnt_r       <= kcnt_nxt;
      ucnt_r       <= ucnt_nxt;
      ktop_r       <= ktop_nxt;
      utop_r       <= utop_nxt;
      pop_kern_r   <= pop_kern_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      sk_valid_r   <= sk_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sk_data_r  <= sk_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (kmem_we) begin
      kmem[kmem_waddr] <= page_w[KW-1:0];
    end
    if (kmem_re) begin
      krd_r <= kmem[kmem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (umem_we) begin
      umem[umem_waddr] <= page_w[KW-1:0];
    end
    if (umem_re) begin
      urd_r <= umem[umem_raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/tppfa_checker.sv -----
// Port-level checker of the allocator and its bind to the top level.
`default_nettype none
`include "two_pool_page_frame_allocator_macros.svh"

module tppfa_checker #(
  parameter int unsigned PAGE_SHIFT = 12
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [tppfa_pkg::ADDR_W-1:0] out_tdata,
  input wire logic [2:0]                   out_tuser
);

  // A stalled result stays in place.
  `TPPFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Any failed operation reports a zero address.
  `TPPFA_ASSERT_NOW(a_err_zero_addr, clk, rst_n,
    out_tvalid && (out_tuser != tppfa_pkg::ST_OK), out_tdata == '0)

  // Every address handed out is page aligned.
  `TPPFA_ASSERT_NOW(a_page_aligned, clk, rst_n, out_tvalid, out_tdata[PAGE_SHIFT-1:0] == '0)

endmodule

bind two_pool_page_frame_allocator tppfa_checker #(.PAGE_SHIFT(PAGE_SHIFT)) u_tppfa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
